[hdl/glos_pkg.sv]
// ============================================================================
// glos_pkg: shared types and constants for the grid line-of-sight block
// Field widths, stream packing, queue entry layout and state encodings.
// ============================================================================
package glos_pkg;

    // Field widths of one input beat.
    localparam int X_W = 8;
    localparam int Y_W = 6;

    // Default map size.
    localparam int DEF_MAP_WIDTH  = 256;
    localparam int DEF_MAP_HEIGHT = 64;

    // Stream widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // Bit positions inside s_tdata.
    localparam int TILE_X_LSB    = 0;
    localparam int TILE_Y_LSB    = TILE_X_LSB + X_W;
    localparam int TILE_OPEN_BIT = TILE_Y_LSB + Y_W;
    localparam int FROM_X_LSB    = TILE_OPEN_BIT + 1;
    localparam int FROM_Y_LSB    = FROM_X_LSB + X_W;
    localparam int TO_X_LSB      = FROM_Y_LSB + Y_W;
    localparam int TO_Y_LSB      = TO_X_LSB + X_W;

    // Walker arithmetic: signed tile coordinates, products and error term.
    localparam int COORD_W = 10;
    localparam int PROD_W  = 2 * X_W;
    localparam int Q_W     = PROD_W + 2;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Action codes carried on s_tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Item classes decided by the front part.
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_NEAR,
        KIND_LINE,
        KIND_WALK
    } glos_kind_t;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_F2,
        ST_MUL_SQ,
        ST_PREP,
        ST_WALK,
        ST_RESULT
    } glos_state_t;

    // One classified item. For writes, from_x/from_y hold the tile to write.
    typedef struct packed {
        glos_kind_t       kind;
        logic             x_major;
        logic             sx_neg;
        logic             sy_neg;
        logic [X_W-1:0]   ax;
        logic [Y_W-1:0]   ay;
        logic [X_W-1:0]   from_x;
        logic [Y_W-1:0]   from_y;
        logic [X_W-1:0]   to_x;
        logic [Y_W-1:0]   to_y;
        logic             tile_open;
    } glos_entry_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } glos_fifo_stat_t;

    // Back part status seen by the front part.
    typedef struct packed {
        logic clearing;
    } glos_back_stat_t;

endpackage

[hdl/glos_front.sv]
// ============================================================================
// glos_front: input beat classifier
// Accepts input beats, computes deltas and directions, sorts each item into
// write, trivial, straight or walked query and pushes it into the queue.
// ============================================================================
module glos_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: tile_x, tile_y, tile_open, from_x,
    // from_y, to_x, to_y, zero padding
    input  logic [glos_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0 up: action
    input  logic                            s_tuser,
    input  glos_pkg::glos_fifo_stat_t       fifo_stat,
    input  glos_pkg::glos_back_stat_t       back_stat,
    output logic                            push,
    output glos_pkg::glos_entry_t           push_entry
);
    import glos_pkg::*;

    logic [X_W-1:0] tile_x;
    logic [Y_W-1:0] tile_y;
    logic           tile_open;
    logic [X_W-1:0] from_x;
    logic [Y_W-1:0] from_y;
    logic [X_W-1:0] to_x;
    logic [Y_W-1:0] to_y;
    logic [X_W:0]   dx;
    logic [Y_W:0]   dy;
    logic [X_W-1:0] ax;
    logic [Y_W-1:0] ay;
    logic           near;
    logic           straight;

    // Unpack the data beat.
    assign tile_x    = s_tdata[TILE_X_LSB +: X_W];
    assign tile_y    = s_tdata[TILE_Y_LSB +: Y_W];
    assign tile_open = s_tdata[TILE_OPEN_BIT];
    assign from_x    = s_tdata[FROM_X_LSB +: X_W];
    assign from_y    = s_tdata[FROM_Y_LSB +: Y_W];
    assign to_x      = s_tdata[TO_X_LSB +: X_W];
    assign to_y      = s_tdata[TO_Y_LSB +: Y_W];

    // Accept while the queue has room and the map clearing pass is over.
    assign s_tready = !fifo_stat.full && !back_stat.clearing;
    assign push     = s_tvalid && s_tready;

    // Signed deltas and their magnitudes.
    assign dx = {1'b0, to_x} - {1'b0, from_x};
    assign dy = {1'b0, to_y} - {1'b0, from_y};
    assign ax = dx[X_W] ? (from_x - to_x) : (to_x - from_x);
    assign ay = dy[Y_W] ? (from_y - to_y) : (to_y - from_y);

    // Neighbors are always visible; rows, columns and knight steps only
    // check tiles on the long axis with the short coordinate fixed.
    assign near     = (ax < X_W'(2)) && (ay < Y_W'(2));
    assign straight = (ax == '0) || (ay == '0)
                   || ((ax == X_W'(1)) && (ay == Y_W'(2)))
                   || ((ax == X_W'(2)) && (ay == Y_W'(1)));

    // Build the queue entry.
    always_comb
    begin
        push_entry.x_major   = (ax >= {2'b00, ay});
        push_entry.sx_neg    = dx[X_W];
        push_entry.sy_neg    = dy[Y_W];
        push_entry.ax        = ax;
        push_entry.ay        = ay;
        push_entry.to_x      = to_x;
        push_entry.to_y      = to_y;
        push_entry.tile_open = tile_open;
        if (s_tuser == ACT_WRITE)
        begin
            push_entry.from_x = tile_x;
            push_entry.from_y = tile_y;
        end
        else
        begin
            push_entry.from_x = from_x;
            push_entry.from_y = from_y;
        end
        priority if (s_tuser == ACT_WRITE)
            push_entry.kind = KIND_WRITE;
        else if (near)
            push_entry.kind = KIND_NEAR;
        else if (straight)
            push_entry.kind = KIND_LINE;
        else
            push_entry.kind = KIND_WALK;
    end

endmodule

[hdl/glos_fifo.sv]
// ============================================================================
// glos_fifo: item queue
// Short first-in first-out queue that decouples the classifier from the
// line walker, so that either side can stall on its own.
// ============================================================================
module glos_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  glos_pkg::glos_entry_t       push_entry,
    input  logic                        pop,
    output glos_pkg::glos_entry_t       head,
    output glos_pkg::glos_fifo_stat_t   fifo_stat
);
    import glos_pkg::*;

    glos_entry_t           entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;

    assign fifo_stat.full  = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign fifo_stat.empty = (count_reg == '0);
    assign head            = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[hdl/glos_back.sv]
// ============================================================================
// glos_back: map store and line walker
// Holds the tile map, clears it after reset, applies writes and walks each
// query one tile per cycle against a registered map read port.
// ============================================================================
module glos_back #(
    parameter int MAP_WIDTH  = glos_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = glos_pkg::DEF_MAP_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  glos_pkg::glos_fifo_stat_t       fifo_stat,
    input  glos_pkg::glos_entry_t           head,
    output logic                            pop,
    output glos_pkg::glos_back_stat_t       back_stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: visible, zero padding
    output logic [glos_pkg::M_TDATA_W-1:0]  m_tdata
);
    import glos_pkg::*;

    localparam int COL_W = $clog2(MAP_WIDTH);
    localparam int ROW_W = $clog2(MAP_HEIGHT);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [Q_W-1:0]     err_t;

    function automatic coord_t coord_step(input logic neg, input coord_t c);
        coord_t r;
        r = neg ? c - 1'b1 : c + 1'b1;
        return r;
    endfunction

    // Tile map: one row of MAP_WIDTH bits per map row.
    logic [MAP_WIDTH-1:0] map_mem [MAP_HEIGHT];

    // Control registers.
    glos_state_t      state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic             out_vis_reg, out_vis_next;
    logic             result_reg, result_next;
    logic             rd_oob_reg, rd_oob_next;
    logic             rd_bit_reg;
    logic             x_major_reg, x_major_next;
    logic             line_reg, line_next;
    logic             smaj_neg_reg, smaj_neg_next;
    logic             smin_neg_reg, smin_neg_next;
    logic             phase_b_reg, phase_b_next;
    logic [X_W-1:0]   amaj_reg, amaj_next;
    logic [X_W-1:0]   amin_reg, amin_next;
    coord_t           maj_reg, maj_next;
    coord_t           min_reg, min_next;
    coord_t           maj_end_reg, maj_end_next;
    logic [PROD_W-1:0] f2_reg, f2_next;
    logic [PROD_W-1:0] sq_reg, sq_next;
    err_t             q_reg, q_next;
    err_t             m_reg, m_next;
    err_t             thr_reg, thr_next;
    err_t             mf_reg, mf_next;

    // Combinational helpers.
    coord_t           maj0;
    coord_t           min0;
    coord_t           tile_x;
    coord_t           tile_y;
    logic             tile_in_map;
    logic [COL_W-1:0] rd_col;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
    logic [ROW_W-1:0] wr_row;
    logic             wr_in_map;
    logic [X_W-1:0]   mul_a;
    logic [PROD_W-1:0] mul_p;
    err_t             m_w;
    err_t             f1_w;
    logic             blocked;

    assign back_stat.clearing = (state_reg == ST_CLEAR);
    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = {{(M_TDATA_W-1){1'b0}}, out_vis_reg};

    // Start coordinates of the queue head in long/short axis terms.
    assign maj0 = head.x_major ? coord_t'({2'b00, head.from_x})
                               : coord_t'({4'b0000, head.from_y});
    assign min0 = head.x_major ? coord_t'({4'b0000, head.from_y})
                               : coord_t'({2'b00, head.from_x});

    // Current walker tile in map terms, and its bounds check.
    assign tile_x      = x_major_reg ? maj_reg : min_reg;
    assign tile_y      = x_major_reg ? min_reg : maj_reg;
    assign tile_in_map = !tile_x[COORD_W-1] && !tile_y[COORD_W-1]
                      && (32'(unsigned'(tile_x)) < MAP_WIDTH)
                      && (32'(unsigned'(tile_y)) < MAP_HEIGHT);
    assign rd_col      = tile_x[COL_W-1:0];
    assign rd_row      = tile_y[ROW_W-1:0];

    // Map write from a write item at the queue head.
    assign wr_in_map = (32'(head.from_x) < MAP_WIDTH) && (32'(head.from_y) < MAP_HEIGHT);
    assign wr_col    = COL_W'(head.from_x);
    assign wr_row    = ROW_W'(head.from_y);

    // One shared 8x8 multiplier for the two setup products.
    assign mul_a = (state_reg == ST_MUL_F2) ? amaj_reg : amin_reg;
    assign mul_p = mul_a * amin_reg;

    // Doubled terms of the error scale.
    assign m_w  = err_t'({1'b0, sq_reg, 1'b0});
    assign f1_w = err_t'({1'b0, f2_reg, 1'b0});

    // A pending read that hit a closed or off-map tile ends the query.
    assign blocked = rd_pend_reg && (rd_oob_reg || !rd_bit_reg);

    // Next state and walker datapath.
    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_vis_next   = out_vis_reg;
        result_next    = result_reg;
        rd_oob_next    = !tile_in_map;
        x_major_next   = x_major_reg;
        line_next      = line_reg;
        smaj_neg_next  = smaj_neg_reg;
        smin_neg_next  = smin_neg_reg;
        phase_b_next   = phase_b_reg;
        amaj_next      = amaj_reg;
        amin_next      = amin_reg;
        maj_next       = maj_reg;
        min_next       = min_reg;
        maj_end_next   = maj_end_reg;
        f2_next        = f2_reg;
        sq_next        = sq_reg;
        q_next         = q_reg;
        m_next         = m_reg;
        thr_next       = thr_reg;
        mf_next        = mf_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            // Clear one map row per cycle after reset.
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(MAP_HEIGHT - 1))
                    state_next = ST_IDLE;
            end

            // Take the next item: apply a write, or set up its query.
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop           = 1'b1;
                    x_major_next  = head.x_major;
                    smaj_neg_next = head.x_major ? head.sx_neg : head.sy_neg;
                    smin_neg_next = head.x_major ? head.sy_neg : head.sx_neg;
                    amaj_next     = head.x_major ? head.ax : {2'b00, head.ay};
                    amin_next     = head.x_major ? {2'b00, head.ay} : head.ax;
                    maj_next      = coord_step(smaj_neg_next, maj0);
                    min_next      = min0;
                    maj_end_next  = head.x_major ? coord_t'({2'b00, head.to_x})
                                                 : coord_t'({4'b0000, head.to_y});
                    phase_b_next  = 1'b0;
                    unique case (head.kind)
                        KIND_WRITE:
                        begin
                            wr_en = wr_in_map;
                        end
                        KIND_NEAR:
                        begin
                            result_next = 1'b1;
                            state_next  = ST_RESULT;
                        end
                        KIND_LINE:
                        begin
                            line_next  = 1'b1;
                            state_next = ST_WALK;
                        end
                        KIND_WALK:
                        begin
                            line_next  = 1'b0;
                            state_next = ST_MUL_F2;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // f2 = long delta times short delta.
            ST_MUL_F2:
            begin
                f2_next    = mul_p;
                state_next = ST_MUL_SQ;
            end

            // Square of the short delta.
            ST_MUL_SQ:
            begin
                sq_next    = mul_p;
                state_next = ST_PREP;
            end

            // Error term start, step sizes and the threshold for a short
            // axis step. A diagonal starts one short step over.
            ST_PREP:
            begin
                m_next   = m_w;
                thr_next = err_t'({2'b00, f2_reg}) - m_w;
                mf_next  = m_w - f1_w;
                if (amaj_reg == amin_reg)
                begin
                    min_next = coord_step(smin_neg_reg, min_reg);
                    q_next   = err_t'({2'b00, sq_reg}) - f1_w;
                end
                else
                begin
                    q_next = err_t'({2'b00, sq_reg});
                end
                state_next = ST_WALK;
            end

            // Issue one tile read per cycle and check the one before.
            ST_WALK:
            begin
                if (blocked)
                begin
                    result_next = 1'b0;
                    state_next  = ST_RESULT;
                end
                else if (!phase_b_reg && (maj_reg == maj_end_reg))
                begin
                    result_next = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    if (phase_b_reg)
                    begin
                        maj_next     = coord_step(smaj_neg_reg, maj_reg);
                        phase_b_next = 1'b0;
                    end
                    else if (line_reg)
                    begin
                        maj_next = coord_step(smaj_neg_reg, maj_reg);
                    end
                    else if (q_reg > thr_reg)
                    begin
                        // Line crosses into the next short row inside this
                        // column: check that tile as well.
                        min_next     = coord_step(smin_neg_reg, min_reg);
                        q_next       = q_reg + mf_reg;
                        phase_b_next = 1'b1;
                    end
                    else if (q_reg == thr_reg)
                    begin
                        // Exact corner touch: step over without a check.
                        min_next = coord_step(smin_neg_reg, min_reg);
                        maj_next = coord_step(smaj_neg_reg, maj_reg);
                        q_next   = q_reg + mf_reg;
                    end
                    else
                    begin
                        maj_next = coord_step(smaj_neg_reg, maj_reg);
                        q_next   = q_reg + m_reg;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walker payload.
    always_ff @(posedge clk)
    begin
        out_vis_reg  <= out_vis_next;
        result_reg   <= result_next;
        rd_oob_reg   <= rd_oob_next;
        x_major_reg  <= x_major_next;
        line_reg     <= line_next;
        smaj_neg_reg <= smaj_neg_next;
        smin_neg_reg <= smin_neg_next;
        phase_b_reg  <= phase_b_next;
        amaj_reg     <= amaj_next;
        amin_reg     <= amin_next;
        maj_reg      <= maj_next;
        min_reg      <= min_next;
        maj_end_reg  <= maj_end_next;
        f2_reg       <= f2_next;
        sq_reg       <= sq_next;
        q_reg        <= q_next;
        m_reg        <= m_next;
        thr_reg      <= thr_next;
        mf_reg       <= mf_next;
    end

    // Map memory: row clear, single bit write and registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            map_mem[clr_row_reg] <= '0;
        else if (wr_en)
            map_mem[wr_row][wr_col] <= head.tile_open;
        rd_bit_reg <= map_mem[rd_row][rd_col];
    end

endmodule

[hdl/grid_line_of_sight.sv]
// ============================================================================
// grid_line_of_sight: tile map line-of-sight engine
// Keeps a one-bit-per-tile map and answers sight queries between two tiles.
// ============================================================================
// Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser selects
// the item: a write sets one map tile and gives no result; a query gives one
// result beat on m_tvalid/m_tready/m_tdata, in input order.
// A write is applied as the walker takes it from the queue. A query between
// equal or neighboring tiles reads no map bits; a row, column or knight step
// reads each tile between the end points; any other query first forms its
// error scale with two multiplies and then reads each tile on the line. The
// rate is set by the walker, which reads one map bit per cycle from a
// registered memory port and stops at the first closed tile.
// A four-entry queue between the classifier and the walker keeps input beats
// flowing while the walker is busy, and a finished result waits in the output
// register while the walker moves on.
// Reset: the map clears one row per cycle with s_tready low; afterwards
// every tile reads as blocked until written.
// When m_tready is low, a result holds on m_tdata and the walker stalls at
// its next result; s_tready drops once the queue fills.
// ============================================================================
module grid_line_of_sight #(
    parameter int MAP_WIDTH  = glos_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = glos_pkg::DEF_MAP_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: tile_x, tile_y, tile_open, from_x,
    // from_y, to_x, to_y, zero padding
    input  logic [glos_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0 up: action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: visible, zero padding
    output logic [glos_pkg::M_TDATA_W-1:0]  m_tdata
);
    import glos_pkg::*;

    logic            push;
    glos_entry_t     push_entry;
    logic            pop;
    glos_entry_t     head;
    glos_fifo_stat_t fifo_stat;
    glos_back_stat_t back_stat;

    // Classifier.
    glos_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_stat  (fifo_stat),
        .back_stat  (back_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Item queue.
    glos_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .fifo_stat  (fifo_stat)
    );

    // Map store and walker.
    glos_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .back_stat (back_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[hdl/glos_checker.sv]
// ============================================================================
// glos_checker: port-level checks for the line-of-sight engine
// Watches the top-level ports for result stability, padding and the quiet
// period that follows reset.
// ============================================================================
module glos_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [glos_pkg::M_TDATA_W-1:0]  m_tdata
);
    import glos_pkg::*;

    // A stalled result beat stays up and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only the visible bit of a result beat may be set.
    a_result_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("result padding bits not zero");

    // The map clearing pass keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge clk)
        !rst_n |=> !s_tready ##1 !s_tready)
        else $error("input open during map clearing");

    // No result can appear in the cycles right after reset.
    a_no_early_result: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid ##1 !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind grid_line_of_sight glos_checker u_glos_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/glos_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// glos_scoreboard: scoreboard for the grid line-of-sight block
// Watches both stream channels, keeps its own copy of the tile map, works out
// the visibility of every accepted query and compares each result beat with
// the oldest outstanding prediction.
// ============================================================================
module glos_scoreboard #(
    parameter int MAP_W = glos_pkg::DEF_MAP_WIDTH,
    parameter int MAP_H = glos_pkg::DEF_MAP_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // s_tdata fields from bit 0 up: tile_x, tile_y, tile_open, from_x,
    // from_y, to_x, to_y, zero padding
    input  logic [glos_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0 up: action
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: visible, zero padding
    input  logic [glos_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending,
    output int                              seen_visible,
    output int                              seen_blocked
);
    import glos_pkg::*;

    // Shadow of the tile map: one bit per tile, 1 when sight passes.
    bit tile_bits [0:MAP_W*MAP_H-1];

    // Predicted visibility of every accepted query, oldest first.
    bit visible_q [$];

    int errors;
    int n_visible;
    int n_blocked;

    // Tiles outside the map always block.
    function automatic bit tile_clear(int x, int y);
        if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_H)
            return 1'b0;
        return tile_bits[y * MAP_W + x];
    endfunction

    // Map lookup in walk coordinates: major axis first.
    function automatic bit walk_tile_ok(bit xmaj, int pmaj, int pmin);
        return xmaj ? tile_clear(pmaj, pmin) : tile_clear(pmin, pmaj);
    endfunction

    // Visibility between two tiles; the end tiles themselves never block.
    function automatic bit sight_passes(int x0, int y0, int x1, int y1);
        int dx;
        int dy;
        int ax;
        int ay;
        int sx;
        int sy;
        int smaj;
        int smin;
        int pmaj;
        int pmin;
        int maj1;
        int f1;
        int f2;
        int q;
        int m;
        bit xmaj;
        dx = x1 - x0;
        dy = y1 - y0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = (dx < 0) ? -1 : 1;
        sy = (dy < 0) ? -1 : 1;

        // Equal or neighboring tiles always see each other.
        if (ax < 2 && ay < 2)
            return 1'b1;

        // Pure column and pure row: every tile in between must be open.
        if (dx == 0)
        begin
            for (pmaj = y0 + sy; pmaj != y1; pmaj += sy)
                if (!tile_clear(x0, pmaj))
                    return 1'b0;
            return 1'b1;
        end
        if (dy == 0)
        begin
            for (pmaj = x0 + sx; pmaj != x1; pmaj += sx)
                if (!tile_clear(pmaj, y0))
                    return 1'b0;
            return 1'b1;
        end

        // Knight steps pass through an open middle tile on the long axis.
        if (ax == 1 && ay == 2 && tile_clear(x0, y0 + sy))
            return 1'b1;
        if (ay == 1 && ax == 2 && tile_clear(x0 + sx, y0))
            return 1'b1;

        // General line: walk the longer axis, error term scaled by 2*ax*ay.
        f2   = ax * ay;
        f1   = 2 * f2;
        xmaj = (ax >= ay);
        q    = xmaj ? ay * ay : ax * ax;
        m    = 2 * q;
        smaj = xmaj ? sx : sy;
        smin = xmaj ? sy : sx;
        pmaj = (xmaj ? x0 : y0) + smaj;
        pmin = xmaj ? y0 : x0;
        maj1 = xmaj ? x1 : y1;
        if (q == f2)
        begin
            pmin += smin;
            q    -= f1;
        end
        while (pmaj != maj1)
        begin
            if (!walk_tile_ok(xmaj, pmaj, pmin))
                return 1'b0;
            q += m;
            if (q > f2)
            begin
                pmin += smin;
                if (!walk_tile_ok(xmaj, pmaj, pmin))
                    return 1'b0;
                q -= f1;
            end
            else if (q == f2)
            begin
                // Exact corner touch: step over without reading it.
                pmin += smin;
                q    -= f1;
            end
            pmaj += smaj;
        end
        return 1'b1;
    endfunction

    // Track accepted beats on both channels.
    always @(posedge clk or negedge rst_n)
    begin : watch
        int x;
        int y;
        bit want;
        bit got;
        if (!rst_n)
        begin
            foreach (tile_bits[i])
                tile_bits[i] = 1'b0;
            visible_q.delete();
            errors    = 0;
            n_visible = 0;
            n_blocked = 0;
        end
        else
        begin
            // Input beat: update the map or predict a query result.
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_WRITE)
                begin
                    x = int'(s_tdata[TILE_X_LSB +: X_W]);
                    y = int'(s_tdata[TILE_Y_LSB +: Y_W]);
                    if (x < MAP_W && y < MAP_H)
                        tile_bits[y * MAP_W + x] = s_tdata[TILE_OPEN_BIT];
                end
                else
                begin
                    visible_q.push_back(sight_passes(
                        int'(s_tdata[FROM_X_LSB +: X_W]),
                        int'(s_tdata[FROM_Y_LSB +: Y_W]),
                        int'(s_tdata[TO_X_LSB +: X_W]),
                        int'(s_tdata[TO_Y_LSB +: Y_W])));
                end
            end

            // Result beat: compare with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[0];
                if (visible_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result beat, m_tdata=%h",
                                 $realtime, m_tdata);
                    errors++;
                end
                else
                begin
                    want = visible_q.pop_front();
                    if (m_tdata[0] !== want || m_tdata[M_TDATA_W-1:1] !== '0)
                    begin
                        if (errors < 10)
                            $display("%0t: visible expected %0d got %b, padding %b",
                                     $realtime, want, m_tdata[0],
                                     m_tdata[M_TDATA_W-1:1]);
                        errors++;
                    end
                    if (got === 1'b1)
                        n_visible++;
                    else
                        n_blocked++;
                end
            end
        end
        fail_count   <= errors;
        pending      <= visible_q.size();
        seen_visible <= n_visible;
        seen_blocked <= n_blocked;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench top for the grid line-of-sight block
// Drives map writes and sight queries in random bursts, stalls the result
// channel on shifting patterns with one long hold-off, and lets the checker
// judge every result beat before giving the verdict.
// ============================================================================
module tb;
    import glos_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int WIN_W        = 12;
    localparam int WIN_H        = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;

    // Result channel stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int seen_visible;
    int seen_blocked;

    int  n_writes;
    int  n_queries;
    int  burst_left;
    bit  hold_req;
    int  win_x;
    int  win_y;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grid_line_of_sight dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    glos_scoreboard scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .seen_visible (seen_visible),
        .seen_blocked (seen_blocked)
    );

    // Pack one input beat, padding bits stay zero.
    function automatic logic [S_TDATA_W-1:0] pack_item(
        int tile_x, int tile_y, bit tile_open,
        int fx, int fy, int tx, int ty);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[TILE_X_LSB +: X_W] = X_W'(tile_x);
        d[TILE_Y_LSB +: Y_W] = Y_W'(tile_y);
        d[TILE_OPEN_BIT]     = tile_open;
        d[FROM_X_LSB +: X_W] = X_W'(fx);
        d[FROM_Y_LSB +: Y_W] = Y_W'(fy);
        d[TO_X_LSB +: X_W]   = X_W'(tx);
        d[TO_Y_LSB +: Y_W]   = Y_W'(ty);
        return d;
    endfunction

    // Offer one beat and wait for it to be taken. Gaps fall between bursts.
    task automatic push_beat(input logic act, input logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 60)
                                              : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        if (act == ACT_QUERY)
            n_queries++;
        else
            n_writes++;
    endtask

    // Map write with random junk in the query fields.
    task automatic write_tile(input int x, input int y, input bit open);
        push_beat(ACT_WRITE, pack_item(x, y, open, $urandom, $urandom,
                                       $urandom, $urandom));
    endtask

    // Sight query with random junk in the write fields.
    task automatic ask_sight(input int fx, input int fy, input int tx, input int ty);
        push_beat(ACT_QUERY, pack_item($urandom, $urandom, 1'($urandom),
                                       fx, fy, tx, ty));
    endtask

    function automatic int pm_one();
        return ($urandom_range(0, 1) == 1) ? 1 : -1;
    endfunction

    // Result channel: changing stall patterns plus one long hold-off.
    initial
    begin : sink
        rx_mode_t mode;
        int       seg_left;
        int       hold_left;
        int       period;
        int       phase;
        m_tready  <= 1'b0;
        seg_left  = 0;
        hold_left = 0;
        period    = 2;
        phase     = 0;
        mode      = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
                period   = $urandom_range(2, 6);
            end
            seg_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= ((phase % period) == 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: directed corner cases, then random traffic around a window.
    initial
    begin : stim
        int pick;
        int shape;
        int squeeze_left;
        int fx;
        int fy;
        int tx;
        int ty;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= ACT_WRITE;
        s_tdata      <= '0;
        n_writes     = 0;
        n_queries    = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        squeeze_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Equal and neighboring tiles, with all-ones write fields.
        push_beat(ACT_QUERY, pack_item('1, '1, 1'b1, 0, 0, 0, 0));
        push_beat(ACT_QUERY, pack_item('1, '1, 1'b1, 255, 63, 254, 62));
        // Row over a blocked map, then opened.
        ask_sight(0, 0, 5, 0);
        push_beat(ACT_WRITE, pack_item(1, 0, 1'b1, '1, '1, '1, '1));
        write_tile(2, 0, 1'b1);
        write_tile(3, 0, 1'b1);
        write_tile(4, 0, 1'b1);
        ask_sight(0, 0, 5, 0);
        ask_sight(5, 0, 0, 0);
        // Full-height column, blocked.
        ask_sight(10, 0, 10, 63);
        // Knight step, middle blocked and then open.
        ask_sight(20, 10, 21, 12);
        write_tile(20, 11, 1'b1);
        ask_sight(20, 10, 21, 12);
        ask_sight(22, 11, 20, 10);
        // Diagonal through exact corners.
        write_tile(31, 31, 1'b1);
        write_tile(32, 32, 1'b1);
        ask_sight(30, 30, 33, 33);
        ask_sight(33, 33, 30, 30);
        // Longest lines across the whole map.
        ask_sight(0, 0, 255, 63);
        ask_sight(255, 0, 0, 63);
        // Extreme tiles written open, and the far corner closed again.
        write_tile(255, 63, 1'b1);
        write_tile(0, 0, 1'b1);
        push_beat(ACT_WRITE, pack_item(255, 63, 1'b0, '1, '1, '1, '1));
        ask_sight(0, 63, 255, 63);
        ask_sight(255, 63, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Move the busy window now and then, often onto a map edge.
            if (i % 150 == 0)
            begin
                win_x = $urandom_range(0, 256 - WIN_W);
                win_y = $urandom_range(0, 64 - WIN_H);
                if ($urandom_range(0, 3) == 0)
                    win_x = $urandom_range(0, 1) ? 256 - WIN_W : 0;
                if ($urandom_range(0, 3) == 0)
                    win_y = $urandom_range(0, 1) ? 64 - WIN_H : 0;
            end

            // Long result hold-off while queries keep coming back to back.
            if (i == 300)
            begin
                hold_req     = 1'b1;
                burst_left   = 48;
                squeeze_left = 48;
            end

            pick = $urandom_range(0, 99);
            if (squeeze_left > 0)
            begin
                squeeze_left--;
                pick = 50;
            end

            if (pick < 35)
            begin
                write_tile(win_x + $urandom_range(0, WIN_W - 1),
                           win_y + $urandom_range(0, WIN_H - 1),
                           $urandom_range(0, 99) < 85);
            end
            else if (pick < 43)
            begin
                write_tile($urandom_range(0, 255), $urandom_range(0, 63),
                           1'($urandom_range(0, 1)));
            end
            else if (pick < 75)
            begin
                ask_sight(win_x + $urandom_range(0, WIN_W - 1),
                          win_y + $urandom_range(0, WIN_H - 1),
                          win_x + $urandom_range(0, WIN_W - 1),
                          win_y + $urandom_range(0, WIN_H - 1));
            end
            else if (pick < 88)
            begin
                // Special shapes inside the window.
                shape = $urandom_range(0, 3);
                fx = win_x + 2 + $urandom_range(0, WIN_W - 5);
                fy = win_y + 2 + $urandom_range(0, WIN_H - 5);
                tx = fx;
                ty = fy;
                case (shape)
                    0:
                    begin
                        tx = fx + $urandom_range(0, 2) - 1;
                        ty = fy + $urandom_range(0, 2) - 1;
                    end
                    1:
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            tx = fx + pm_one();
                            ty = fy + 2 * pm_one();
                        end
                        else
                        begin
                            tx = fx + 2 * pm_one();
                            ty = fy + pm_one();
                        end
                    end
                    2:
                    begin
                        fx = win_x + $urandom_range(0, WIN_W - 1);
                        tx = win_x + $urandom_range(0, WIN_W - 1);
                    end
                    default:
                    begin
                        fy = win_y + $urandom_range(0, WIN_H - 1);
                        ty = win_y + $urandom_range(0, WIN_H - 1);
                    end
                endcase
                ask_sight(fx, fy, tx, ty);
            end
            else
            begin
                ask_sight($urandom_range(0, 255), $urandom_range(0, 63),
                          $urandom_range(0, 255), $urandom_range(0, 63));
            end
        end
        s_tvalid <= 1'b0;

        // Let the count of outstanding queries catch up with the last beat.
        repeat (2) @(posedge clk);

        // Drain outstanding results, then give late beats a chance to show.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d map writes and %0d sight queries, with a %0d-cycle",
                 n_writes, n_queries, HOLD_CYCLES);
        $display("result hold-off; %0d results were visible and %0d blocked.",
                 seen_visible, seen_blocked);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #20_000_000;
        $display("Timeout: run did not complete.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
